// ----- rtl/ckb_pkg.sv -----
package ckb_pkg;

    localparam int MAX_DIM_DEF = 4096;

    // fixed field widths
    localparam int ORG_W   = 12;
    localparam int DIM_IN_W = 13;
    localparam int SCR_W   = 13;
    localparam int PITCH_W = 14;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 26;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 2'd0,
        REG_SCREEN_HEIGHT = 2'd1,
        REG_ROW_PITCH     = 2'd2,
        REG_COLOR_KEY     = 2'd3
    } t_cfg_reg;

    localparam logic [COLOR_W-1:0] KEY_RESET = 32'h00FF_00FF;

endpackage

// ----- rtl/color_keyed_clipped_blit.sv -----
// channel  | handshake                 | payload
// ---------+---------------------------+------------------------------------------
// pixel in | i_in_valid / o_in_stall   | first_pixel, origin, image size, colour
// fb write | o_out_valid / i_out_stall | write_enable, fb_address, write_color, last
// config   | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; an item is registered in the
// raster/clip stage, then the address multiply-add goes into the output register.
// Reset is synchronous, active low; colour key resets to magenta, others to zero.
// Stalls back up stage by stage: an item is still taken while a result waits,
// as long as the raster stage is free.
module color_keyed_clipped_blit #(
    parameter int MAX_DIM = ckb_pkg::MAX_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_first_pixel,
    input  logic [ckb_pkg::ORG_W-1:0]      i_origin_x,
    input  logic [ckb_pkg::ORG_W-1:0]      i_origin_y,
    input  logic [ckb_pkg::DIM_IN_W-1:0]   i_image_width,
    input  logic [ckb_pkg::DIM_IN_W-1:0]   i_image_height,
    input  logic [ckb_pkg::COLOR_W-1:0]    i_pixel_color,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_write_enable,
    output logic [ckb_pkg::ADDR_W-1:0]     o_fb_address,
    output logic [ckb_pkg::COLOR_W-1:0]    o_write_color,
    output logic                           o_last,
    input  logic                           i_cfg_we,
    input  logic [ckb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ckb_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int DX_W  = ((CNT_W > ckb_pkg::ORG_W) ? CNT_W : ckb_pkg::ORG_W) + 1;
    localparam int SUM_W = DX_W + ckb_pkg::PITCH_W + 1;

    logic [ckb_pkg::SCR_W-1:0]   r_scr_w, r_scr_h;
    logic [ckb_pkg::PITCH_W-1:0] r_pitch;
    logic [ckb_pkg::COLOR_W-1:0] r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= '0;
            r_scr_h <= '0;
            r_pitch <= '0;
            r_key   <= ckb_pkg::KEY_RESET;
        end else if (i_cfg_we) begin
            unique case (ckb_pkg::t_cfg_reg'(i_cfg_index))
                ckb_pkg::REG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data[ckb_pkg::SCR_W-1:0];
                ckb_pkg::REG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data[ckb_pkg::SCR_W-1:0];
                ckb_pkg::REG_ROW_PITCH:     r_pitch <= i_cfg_data[ckb_pkg::PITCH_W-1:0];
                ckb_pkg::REG_COLOR_KEY:     r_key   <= i_cfg_data[ckb_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    logic                        s1_valid, s1_we, s1_last, out_free;
    logic [DX_W-1:0]             s1_dx, s1_dy;
    logic [ckb_pkg::COLOR_W-1:0] s1_color;

    assign out_free = !o_out_valid || !i_out_stall;

    ckb_raster #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W),
        .DX_W    (DX_W)
    ) u_raster (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_first_pixel   (i_first_pixel),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_image_width   (i_image_width),
        .i_image_height  (i_image_height),
        .i_pixel_color   (i_pixel_color),
        .i_screen_width  (r_scr_w),
        .i_screen_height (r_scr_h),
        .i_color_key     (r_key),
        .i_out_free      (out_free),
        .o_valid         (s1_valid),
        .o_dx            (s1_dx),
        .o_dy            (s1_dy),
        .o_we            (s1_we),
        .o_last          (s1_last),
        .o_color         (s1_color)
    );

    logic [SUM_W-1:0] n_sum;
    logic             r_out_valid, n_out_valid;
    logic             r_we, r_last;
    logic [ckb_pkg::ADDR_W-1:0]  r_addr;
    logic [ckb_pkg::COLOR_W-1:0] r_color;

    assign n_sum = SUM_W'(SUM_W'(s1_dy) * SUM_W'(r_pitch)) + SUM_W'(s1_dx);

    always_comb begin
        if (out_free) begin
            n_out_valid = s1_valid;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_valid) begin
            r_we    <= s1_we;
            r_last  <= s1_last;
            r_addr  <= n_sum[ckb_pkg::ADDR_W-1:0];
            r_color <= s1_color;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_write_enable = r_we;
    assign o_fb_address   = r_addr;
    assign o_write_color  = r_color;
    assign o_last         = r_last;

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && out_free) |=> o_out_valid)
        else $error("raster stage item lost on its way to the output");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (s1_valid && o_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_in_valid && !i_out_stall) ##1 (!i_in_valid && !i_out_stall) |=> !o_out_valid)
        else $error("pipeline did not drain");

endmodule

// ----- rtl/ckb_raster.sv -----
module ckb_raster #(
    parameter int MAX_DIM = ckb_pkg::MAX_DIM_DEF,
    parameter int CNT_W   = $clog2(MAX_DIM),
    parameter int DX_W    = ((CNT_W > ckb_pkg::ORG_W) ? CNT_W : ckb_pkg::ORG_W) + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_first_pixel,
    input  logic [ckb_pkg::ORG_W-1:0]     i_origin_x,
    input  logic [ckb_pkg::ORG_W-1:0]     i_origin_y,
    input  logic [ckb_pkg::DIM_IN_W-1:0]  i_image_width,
    input  logic [ckb_pkg::DIM_IN_W-1:0]  i_image_height,
    input  logic [ckb_pkg::COLOR_W-1:0]   i_pixel_color,
    input  logic [ckb_pkg::SCR_W-1:0]     i_screen_width,
    input  logic [ckb_pkg::SCR_W-1:0]     i_screen_height,
    input  logic [ckb_pkg::COLOR_W-1:0]   i_color_key,
    input  logic                          i_out_free,
    output logic                          o_valid,
    output logic [DX_W-1:0]               o_dx,
    output logic [DX_W-1:0]               o_dy,
    output logic                          o_we,
    output logic                          o_last,
    output logic [ckb_pkg::COLOR_W-1:0]   o_color
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DX_W > ckb_pkg::SCR_W) ? DX_W : ckb_pkg::SCR_W;

    // zero acts as one, oversize clamps to MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [ckb_pkg::DIM_IN_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (32'(d) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    logic [CNT_W-1:0]          r_col, r_row, n_col, n_row;
    logic [ckb_pkg::ORG_W-1:0] r_ox, r_oy, n_ox, n_oy;
    logic [DIM_W-1:0]          r_w, r_h, n_w, n_h;
    logic                      r_valid, n_valid;
    logic [DX_W-1:0]           r_dx, r_dy, n_dx, n_dy;
    logic                      r_we, r_last, n_we, n_last;
    logic [ckb_pkg::COLOR_W-1:0] r_color;

    logic             accept;
    logic [CNT_W-1:0] col_cur, row_cur;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             on_screen;

    assign o_in_stall = r_valid && !i_out_free;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_ox = r_ox;
        n_oy = r_oy;
        n_w  = r_w;
        n_h  = r_h;
        col_cur = r_col;
        row_cur = r_row;
        if (i_first_pixel) begin
            n_ox = i_origin_x;
            n_oy = i_origin_y;
            n_w  = eff_dim(i_image_width);
            n_h  = eff_dim(i_image_height);
            col_cur = '0;
            row_cur = '0;
        end

        n_dx = DX_W'(n_ox) + DX_W'(col_cur);
        n_dy = DX_W'(n_oy) + DX_W'(row_cur);
        on_screen = (CMP_W'(n_dx) < CMP_W'(i_screen_width))
                 && (CMP_W'(n_dy) < CMP_W'(i_screen_height));
        n_we   = on_screen && (i_pixel_color != i_color_key);
        n_last = (DIM_W'(col_cur) == n_w - DIM_W'(1))
              && (DIM_W'(row_cur) == n_h - DIM_W'(1));

        // raster advance with wrap back to the top-left
        col_inc = DIM_W'(col_cur) + DIM_W'(1);
        row_inc = DIM_W'(row_cur) + DIM_W'(1);
        if (col_inc >= n_w) begin
            n_col = '0;
            n_row = (row_inc >= n_h) ? '0 : row_inc[CNT_W-1:0];
        end else begin
            n_col = col_inc[CNT_W-1:0];
            n_row = row_cur;
        end

        if (accept) begin
            n_valid = 1'b1;
        end else if (i_out_free) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_ox    <= '0;
            r_oy    <= '0;
            r_w     <= DIM_W'(1);
            r_h     <= DIM_W'(1);
        end else begin
            r_valid <= n_valid;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_ox  <= n_ox;
                r_oy  <= n_oy;
                r_w   <= n_w;
                r_h   <= n_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_we    <= n_we;
            r_last  <= n_last;
            r_color <= i_pixel_color;
        end
    end

    assign o_valid = r_valid;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_we    = r_we;
    assign o_last  = r_last;
    assign o_color = r_color;

    a_col_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < r_w)
        else $error("column counter beyond latched width");

    a_row_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_row) < r_h)
        else $error("row counter beyond latched height");

    a_dim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_w != '0) && (32'(r_w) <= MAX_DIM) && (r_h != '0) && (32'(r_h) <= MAX_DIM))
        else $error("latched size out of range");

endmodule

// ----- dv/color_keyed_clipped_blit_checker.sv -----
module color_keyed_clipped_blit_checker
    import ckb_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_first_pixel,
    input  logic [ORG_W-1:0]     i_origin_x,
    input  logic [ORG_W-1:0]     i_origin_y,
    input  logic [DIM_IN_W-1:0]  i_image_width,
    input  logic [DIM_IN_W-1:0]  i_image_height,
    input  logic [COLOR_W-1:0]   i_pixel_color,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_write_enable,
    input  logic [ADDR_W-1:0]    i_fb_address,
    input  logic [COLOR_W-1:0]   i_write_color,
    input  logic                 i_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_mismatch_count,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W = $clog2(MAX_DIM);

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               last;
    } fb_write_t;

    logic [SCR_W-1:0]    scr_width;
    logic [SCR_W-1:0]    scr_height;
    logic [PITCH_W-1:0]  pitch;
    logic [COLOR_W-1:0]  key_color;

    logic [CNT_W-1:0]    col_cnt;
    logic [CNT_W-1:0]    row_cnt;
    logic [ORG_W-1:0]    org_x;
    logic [ORG_W-1:0]    org_y;
    logic [DIM_IN_W-1:0] img_width;
    logic [DIM_IN_W-1:0] img_height;

    fb_write_t fb_writes_due[$];
    int        mismatches;

    initial begin
        mismatches = 0;
        o_mismatch_count = 0;
        o_outstanding = 0;
    end

    function automatic int clamp_dim(input logic [DIM_IN_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Advances the raster position and returns the framebuffer write for one pixel.
    function automatic fb_write_t blit_pixel(
        input logic                first,
        input logic [ORG_W-1:0]    ox,
        input logic [ORG_W-1:0]    oy,
        input logic [DIM_IN_W-1:0] w,
        input logic [DIM_IN_W-1:0] h,
        input logic [COLOR_W-1:0]  color
    );
        int          w_eff;
        int          h_eff;
        int          dx;
        int          dy;
        logic [63:0] full_addr;
        fb_write_t   wr;
        if (first) begin
            org_x = ox;
            org_y = oy;
            img_width = w;
            img_height = h;
            col_cnt = '0;
            row_cnt = '0;
        end
        w_eff = clamp_dim(img_width);
        h_eff = clamp_dim(img_height);
        if (int'(col_cnt) >= w_eff)
            col_cnt = '0;
        if (int'(row_cnt) >= h_eff)
            row_cnt = '0;
        dx = int'(org_x) + int'(col_cnt);
        dy = int'(org_y) + int'(row_cnt);
        full_addr = 64'(dy) * 64'(pitch) + 64'(dx);
        wr.wr_en = (dx < int'(scr_width)) && (dy < int'(scr_height)) && (color != key_color);
        wr.addr  = full_addr[ADDR_W-1:0];
        wr.color = color;
        wr.last  = (int'(col_cnt) == w_eff - 1) && (int'(row_cnt) == h_eff - 1);
        if (int'(col_cnt) + 1 >= w_eff) begin
            col_cnt = '0;
            row_cnt = (int'(row_cnt) + 1 >= h_eff) ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        return wr;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        fb_write_t exp_wr;
        if (!i_rst_n) begin
            scr_width  = '0;
            scr_height = '0;
            pitch      = '0;
            key_color  = KEY_RESET;
            col_cnt    = '0;
            row_cnt    = '0;
            org_x      = '0;
            org_y      = '0;
            img_width  = '0;
            img_height = '0;
            fb_writes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_SCREEN_WIDTH:  scr_width  = i_cfg_data[SCR_W-1:0];
                    REG_SCREEN_HEIGHT: scr_height = i_cfg_data[SCR_W-1:0];
                    REG_ROW_PITCH:     pitch      = i_cfg_data[PITCH_W-1:0];
                    REG_COLOR_KEY:     key_color  = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                fb_writes_due.push_back(blit_pixel(i_first_pixel, i_origin_x, i_origin_y,
                                                   i_image_width, i_image_height,
                                                   i_pixel_color));
            if (i_out_valid && !i_out_stall) begin
                if (fb_writes_due.size() == 0) begin
                    note_mismatch("unexpected write", '0, i_fb_address);
                end else begin
                    exp_wr = fb_writes_due.pop_front();
                    if (i_write_enable !== exp_wr.wr_en)
                        note_mismatch("write_enable", exp_wr.wr_en, i_write_enable);
                    if (i_fb_address !== exp_wr.addr)
                        note_mismatch("fb_address", exp_wr.addr, i_fb_address);
                    if (i_write_color !== exp_wr.color)
                        note_mismatch("write_color", exp_wr.color, i_write_color);
                    if (i_last !== exp_wr.last)
                        note_mismatch("last", exp_wr.last, i_last);
                end
            end
        end
        o_outstanding = fb_writes_due.size();
        o_mismatch_count = mismatches;
    end

endmodule

// ----- dv/color_keyed_clipped_blit_test.sv -----
module color_keyed_clipped_blit_test;
    import ckb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 90;
    localparam int RANDOM_PHASES = 5;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_first_pixel;
    logic [ORG_W-1:0]     i_origin_x;
    logic [ORG_W-1:0]     i_origin_y;
    logic [DIM_IN_W-1:0]  i_image_width;
    logic [DIM_IN_W-1:0]  i_image_height;
    logic [COLOR_W-1:0]   i_pixel_color;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_write_enable;
    logic [ADDR_W-1:0]    o_fb_address;
    logic [COLOR_W-1:0]   o_write_color;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int mismatch_count;
    int outstanding;
    int cycles;
    int burst_left;
    int phase_items;
    bit pressure_go;

    logic [SCR_W-1:0]   cur_width;
    logic [SCR_W-1:0]   cur_height;
    logic [COLOR_W-1:0] cur_key;

    color_keyed_clipped_blit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_pixel  (i_first_pixel),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_image_width  (i_image_width),
        .i_image_height (i_image_height),
        .i_pixel_color  (i_pixel_color),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_write_enable (o_write_enable),
        .o_fb_address   (o_fb_address),
        .o_write_color  (o_write_color),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    color_keyed_clipped_blit_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_first_pixel    (i_first_pixel),
        .i_origin_x       (i_origin_x),
        .i_origin_y       (i_origin_y),
        .i_image_width    (i_image_width),
        .i_image_height   (i_image_height),
        .i_pixel_color    (i_pixel_color),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_write_enable   (o_write_enable),
        .i_fb_address     (o_fb_address),
        .i_write_color    (o_write_color),
        .i_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: stretches of no stalling, light and heavy random stalling,
    // and long hold-offs that let the pipe fill up.
    initial begin
        int mode;
        int len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 9);
            len = $urandom_range(10, 120);
            if (pressure_go) begin
                pressure_go = 1'b0;
                mode = 9;
            end
            if (mode == 9)
                len = $urandom_range(60, 150);
            for (int c = 0; c < len; c++) begin
                case (mode)
                    0, 1, 2: i_out_stall <= 1'b0;
                    3, 4, 5: i_out_stall <= ($urandom_range(0, 3) == 0);
                    6, 7, 8: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= 1'b1;
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic int new_burst();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(30, 80);
        return $urandom_range(1, 12);
    endfunction

    task automatic send_pixel(input logic first, input logic [ORG_W-1:0] ox,
                              input logic [ORG_W-1:0] oy, input logic [DIM_IN_W-1:0] w,
                              input logic [DIM_IN_W-1:0] h, input logic [COLOR_W-1:0] color);
        i_in_valid     <= 1'b1;
        i_first_pixel  <= first;
        i_origin_x     <= ox;
        i_origin_y     <= oy;
        i_image_width  <= w;
        i_image_height <= h;
        i_pixel_color  <= color;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        phase_items++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = new_burst();
        end
    endtask

    // non-first pixels carry junk in the header fields
    task automatic send_plain(input logic [COLOR_W-1:0] color);
        send_pixel(1'b0, ORG_W'($urandom), ORG_W'($urandom), DIM_IN_W'($urandom),
                   DIM_IN_W'($urandom), color);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        if ($urandom_range(0, 4) == 0)
            return cur_key;
        return $urandom;
    endfunction

    task automatic send_image(input logic [ORG_W-1:0] ox, input logic [ORG_W-1:0] oy,
                              input logic [DIM_IN_W-1:0] w, input logic [DIM_IN_W-1:0] h,
                              input int count);
        send_pixel(1'b1, ox, oy, w, h, pick_color());
        for (int n = 1; n < count; n++)
            send_plain(pick_color());
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_SCREEN_WIDTH:  cur_width  = value[SCR_W-1:0];
            REG_SCREEN_HEIGHT: cur_height = value[SCR_W-1:0];
            REG_COLOR_KEY:     cur_key    = value;
            default: ;
        endcase
    endtask

    task automatic set_screen(input int w, input int h, input int p,
                              input logic [COLOR_W-1:0] key);
        write_reg(REG_SCREEN_WIDTH, CFG_W'(w));
        write_reg(REG_SCREEN_HEIGHT, CFG_W'(h));
        write_reg(REG_ROW_PITCH, CFG_W'(p));
        write_reg(REG_COLOR_KEY, key);
    endtask

    // origins cluster around the screen edge so clipping gets exercised
    function automatic logic [ORG_W-1:0] pick_coord(input int edge_at);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 4095);
            1: v = edge_at - int'($urandom_range(0, 8));
            2: v = $urandom_range(0, 15);
            default: v = edge_at + int'($urandom_range(0, 3));
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return ORG_W'(v);
    endfunction

    task automatic random_phase();
        int w;
        int h;
        int total;
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            total = w * h;
            case ($urandom_range(0, 9))
                0: begin
                    send_pixel(1'($urandom), ORG_W'($urandom), ORG_W'($urandom),
                               DIM_IN_W'($urandom), DIM_IN_W'($urandom), $urandom);
                end
                1: begin
                    // truncated image, or a single pixel that runs on and wraps
                    send_image(pick_coord(cur_width), pick_coord(cur_height), w, h,
                               (total > 1) ? $urandom_range(1, total - 1)
                                           : $urandom_range(2, 4));
                end
                2: begin
                    send_image(pick_coord(cur_width), pick_coord(cur_height),
                               ($urandom_range(0, 1) != 0) ? 13'd4096 : 13'h1FFF,
                               DIM_IN_W'($urandom_range(0, 8191)), $urandom_range(1, 6));
                end
                3: begin
                    send_image(pick_coord(cur_width), pick_coord(cur_height),
                               '0, DIM_IN_W'($urandom_range(0, 3)), $urandom_range(1, 3));
                end
                default: begin
                    send_image(pick_coord(cur_width), pick_coord(cur_height),
                               DIM_IN_W'(w), DIM_IN_W'(h), total);
                end
            endcase
        end
        wait_idle();
    endtask

    initial begin
        pressure_go = 1'b0;
        cur_width = '0;
        cur_height = '0;
        cur_key = KEY_RESET;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_first_pixel  <= 1'b0;
        i_origin_x     <= '0;
        i_origin_y     <= '0;
        i_image_width  <= '0;
        i_image_height <= '0;
        i_pixel_color  <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= REG_SCREEN_WIDTH;
        i_cfg_data     <= '0;
        burst_left = new_burst();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no image started yet and a zero-sized screen: 1x1 image at the origin
        send_plain(KEY_RESET);
        send_plain(32'h1234_5678);
        wait_idle();

        set_screen(640, 480, 640, 32'h0012_3456);
        send_pixel(1'b1, 12'd0, 12'd0, 13'd3, 13'd2, 32'h0000_0000);
        send_plain(32'hFFFF_FFFF);
        send_plain(32'h0012_3456);
        send_plain(32'h00FF_00FF);
        send_plain($urandom);
        send_plain($urandom);
        // running past the last pixel wraps round to the top-left
        send_plain($urandom);
        send_plain(32'h0012_3456);
        // origin off screen
        send_pixel(1'b1, 12'hFFF, 12'hFFF, 13'd2, 13'd1, $urandom);
        send_plain($urandom);
        // straddles the bottom-right corner
        send_pixel(1'b1, 12'd638, 12'd479, 13'd3, 13'd2, $urandom);
        for (int n = 0; n < 5; n++)
            send_plain($urandom);
        // zero size behaves as one
        send_pixel(1'b1, 12'd5, 12'd7, 13'd0, 13'd0, $urandom);
        send_plain($urandom);
        // oversized image is clamped
        send_pixel(1'b1, 12'd1, 12'd1, 13'h1FFF, 13'h1FFF, $urandom);
        send_plain($urandom);
        send_pixel(1'b1, 12'hFFF, 12'd0, 13'd4096, 13'd1, $urandom);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_screen(4096, 4096, 8192, $urandom);
                1: set_screen(0, $urandom_range(1, 4096), $urandom_range(0, 8192), $urandom);
                // pitch beyond the usual range pushes the address past 26 bits
                2: set_screen($urandom_range(1, 4096), $urandom_range(1, 4096), 16383, '0);
                3: set_screen(1, 1, 0, 32'hFFFF_FFFF);
                default: set_screen($urandom_range(0, 4096), $urandom_range(0, 4096),
                                    $urandom_range(0, 8192), $urandom);
            endcase
            if (p == 0)
                pressure_go = 1'b1;
            random_phase();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/ckb_pkg.sv
rtl/ckb_raster.sv
rtl/color_keyed_clipped_blit.sv
dv/color_keyed_clipped_blit_checker.sv
dv/color_keyed_clipped_blit_test.sv
